### rtl/mqfifo_pkg.sv
// ----------------------------------------------------------------------------
// Multi-queue FIFO package
// Field widths, action and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package mqfifo_pkg;

  localparam int ACTION_W = 2;
  localparam int QUEUE_W  = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LOST_W   = 32;

  // Action codes carried by the action field.
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Status codes returned with every result.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_QUEUE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;    // Execute the action presented on the input ports.
    logic load_result;  // Move the finished result into the output register.
  } cmd_t;

endpackage

### rtl/multi_queue_fifo_with_drop_count.sv
// ----------------------------------------------------------------------------
// Multi-queue FIFO with drop count
// Latency: a result is loaded at the clock edge after its beat is accepted and
// is valid from then on; a result still waiting on the output holds it back.
// No new beat is taken until the last result is loaded; the execute step waits
// for the registered read of the word store before the result is loaded.
// Reset clears all pointers, fill counts, lost counters and the created count.
// ----------------------------------------------------------------------------
//
// The block holds QUEUES ring FIFOs of DEPTH slots each in one shared word
// store. Each input beat carries one action on one queue:
//   - Init resets the queue's read and write pointers, fill count and lost
//     counter and bumps the created-queue count. Once that count has reached
//     QUEUES, init is refused with the no-more-queues status.
//   - Write appends a word unless the queue already holds DEPTH-1 words; in
//     that case the word is dropped, the queue's lost counter is incremented
//     (saturating at all ones) and the full status is returned.
//   - Read pops the oldest word, or returns the empty status.
// A queue number at or above QUEUES returns no-more-queues with zero lost
// total and changes nothing.
//
// The controller accepts a beat only when idle. On the accepting edge the
// datapath updates the queue state, writes the word store or issues its read,
// and latches the status and lost total. In the following cycle the result is
// loaded into the output register as soon as that register is free, so one
// finished result can wait on the output side while the next beat is taken.
// The word store has no reset; a read only ever returns words written since
// the queue's last init.
module multi_queue_fifo_with_drop_count
  import mqfifo_pkg::*;
#(
  parameter int QUEUES = 4,
  parameter int DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ACTION_W-1:0]      action_i,
  input  logic [QUEUE_W-1:0]       queue_i,
  input  logic signed [WORD_W-1:0] word_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [WORD_W-1:0] word_out_o,
  output logic [LOST_W-1:0]        lost_total_o
);

  cmd_t cmd;

  // Sequencing and output handshake.
  mqfifo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Queue state, word store and result registers.
  mqfifo_dp #(
    .QUEUES (QUEUES),
    .DEPTH  (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .queue_i      (queue_i),
    .word_in_i    (word_in_i),
    .status_o     (status_o),
    .word_out_o   (word_out_o),
    .lost_total_o (lost_total_o)
  );

endmodule

### rtl/mqfifo_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-queue FIFO controller
// Sequences one action at a time and owns the output valid flag.
// ----------------------------------------------------------------------------
module mqfifo_ctrl
  import mqfifo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.take_item   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.load_result = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_goes_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted beat did not start execution");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result appeared without an executed action");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && out_stall_i) |=> (state_q == S_EXEC))
    else $error("pending result overwrote an untaken result");
`endif

endmodule

### rtl/mqfifo_dp.sv
// ----------------------------------------------------------------------------
// Multi-queue FIFO datapath
// Per-queue pointers, fill counts and lost counters, the shared word store,
// and the result registers.
// ----------------------------------------------------------------------------
module mqfifo_dp
  import mqfifo_pkg::*;
#(
  parameter int QUEUES = 4,
  parameter int DEPTH  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic [ACTION_W-1:0]        action_i,
  input  logic [QUEUE_W-1:0]         queue_i,
  input  logic signed [WORD_W-1:0]   word_in_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [WORD_W-1:0]   word_out_o,
  output logic [LOST_W-1:0]          lost_total_o
);

  localparam int PW      = $clog2(DEPTH);
  localparam int CW      = $clog2(QUEUES + 1);
  localparam int QIW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QXW     = (QIW > QUEUE_W) ? QIW : QUEUE_W;
  localparam int ENTRIES = QUEUES * DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [PW-1:0]     rp_q   [QUEUES];
  logic [PW-1:0]     wp_q   [QUEUES];
  logic [PW-1:0]     fill_q [QUEUES];
  logic [LOST_W-1:0] lost_q [QUEUES];
  logic [CW-1:0]     created_q;

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_data_q;

  logic [STATUS_W-1:0] status_hold_q;
  logic [LOST_W-1:0]   lost_hold_q;
  logic                rd_ok_q;

  logic [STATUS_W-1:0] status_q;
  logic [WORD_W-1:0]   word_out_q;
  logic [LOST_W-1:0]   lost_out_q;

  logic [QXW-1:0]      q_ext;
  logic [QIW-1:0]      qi;
  logic                q_ok;
  logic [PW-1:0]       rp_cur, wp_cur, fill_cur;
  logic [LOST_W-1:0]   lost_cur, lost_new;
  logic [STATUS_W-1:0] status_new;
  logic                do_init, do_write, do_read, do_drop;
  logic [AW-1:0]       wr_addr, rd_addr;

  always_comb begin
    q_ext    = QXW'(queue_i);
    qi       = q_ext[QIW-1:0];
    q_ok     = ({30'b0, queue_i} < 32'(QUEUES));
    rp_cur   = q_ok ? rp_q[qi]   : '0;
    wp_cur   = q_ok ? wp_q[qi]   : '0;
    fill_cur = q_ok ? fill_q[qi] : '0;
    lost_cur = q_ok ? lost_q[qi] : '0;

    status_new = ST_OK;
    lost_new   = lost_cur;
    do_init    = 1'b0;
    do_write   = 1'b0;
    do_read    = 1'b0;
    do_drop    = 1'b0;

    if (!q_ok) begin
      status_new = ST_NO_QUEUE;
      lost_new   = '0;
    end else begin
      case (action_i)
        ACT_INIT: begin
          if (created_q >= CW'(QUEUES)) begin
            status_new = ST_NO_QUEUE;
          end else begin
            do_init  = 1'b1;
            lost_new = '0;
          end
        end
        ACT_WRITE: begin
          if (fill_cur == LAST_SLOT) begin
            status_new = ST_FULL;
            do_drop    = 1'b1;
            if (lost_cur != '1) begin
              lost_new = lost_cur + 1'b1;
            end
          end else begin
            do_write = 1'b1;
          end
        end
        ACT_READ: begin
          if (fill_cur == '0) begin
            status_new = ST_EMPTY;
          end else begin
            do_read = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    wr_addr = AW'(qi) * AW'(DEPTH) + AW'(wp_cur);
    rd_addr = AW'(qi) * AW'(DEPTH) + AW'(rp_cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        rp_q[i]   <= '0;
        wp_q[i]   <= '0;
        fill_q[i] <= '0;
        lost_q[i] <= '0;
      end
      created_q <= '0;
    end else if (cmd_i.take_item) begin
      if (do_init) begin
        rp_q[qi]   <= '0;
        wp_q[qi]   <= '0;
        fill_q[qi] <= '0;
        lost_q[qi] <= '0;
        created_q  <= created_q + 1'b1;
      end
      if (do_write) begin
        wp_q[qi]   <= (wp_cur == LAST_SLOT) ? '0 : wp_cur + 1'b1;
        fill_q[qi] <= fill_cur + 1'b1;
      end
      if (do_read) begin
        rp_q[qi]   <= (rp_cur == LAST_SLOT) ? '0 : rp_cur + 1'b1;
        fill_q[qi] <= fill_cur - 1'b1;
      end
      if (do_drop) begin
        lost_q[qi] <= lost_new;
      end
    end
  end

  // Word store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && do_write) begin
      mem[wr_addr] <= word_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && do_read) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      status_hold_q <= status_new;
      lost_hold_q   <= lost_new;
      rd_ok_q       <= do_read;
    end
    if (cmd_i.load_result) begin
      status_q   <= status_hold_q;
      word_out_q <= rd_ok_q ? rd_data_q : '0;
      lost_out_q <= lost_hold_q;
    end
  end

  assign status_o     = status_q;
  assign word_out_o   = word_out_q;
  assign lost_total_o = lost_out_q;

`ifndef SYNTH
  a_created_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q <= CW'(QUEUES))
    else $error("created queue count passed the number of queues");

  for (genvar g = 0; g < QUEUES; g++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      fill_q[g] <= LAST_SLOT)
      else $error("queue fill count passed its capacity");
  end
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue FIFO with drop count testbench
// Drives actions on the input channel and checks every result beat against
// a predictor of the FIFO bank. A directed table comes first, then random
// bursts that fill, overflow and drain the queues, with random gaps on both
// sides, one long output hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module tb_top
  import mqfifo_pkg::*;
();

  localparam int QUEUES      = 4;
  localparam int DEPTH       = 16;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int FILL_W      = $clog2(DEPTH) + 1;
  localparam int MADE_W      = $clog2(QUEUES) + 1;
  localparam int IDLE_PCT    = 32;
  localparam int RANDOM_BEATS = 1080;
  localparam int BURST_LEN   = 40;
  localparam int HOLD_AT     = 650;
  localparam int HOLD_CYCLES = 150;
  localparam int N_ROWS      = 22;

  // The action field can also carry the unused code; the block must treat it
  // as a no-op that still reports the queue's lost counter.
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] word;
    logic [LOST_W-1:0]        lost;
  } fifo_result_t;

  // One row of the directed table. The beat is repeated reps times with the
  // word stepped by one each time. Where typed is set, the result written in
  // the row is the expectation; otherwise the predictor supplies it.
  typedef struct packed {
    logic [ACTION_W-1:0]      act;
    logic [QUEUE_W-1:0]       q;
    logic signed [WORD_W-1:0] word;
    logic [4:0]               reps;
    logic                     typed;
    fifo_result_t             res;
  } stim_row_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic [ACTION_W-1:0]      action_i     = ACT_INIT;
  logic [QUEUE_W-1:0]       queue_i      = '0;
  logic signed [WORD_W-1:0] word_in_i    = '0;
  logic                     out_stall_i  = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [STATUS_W-1:0]      status_o;
  logic signed [WORD_W-1:0] word_out_o;
  logic [LOST_W-1:0]        lost_total_o;

  // Predictor copy of the FIFO bank.
  logic signed [WORD_W-1:0] bank_words [QUEUES][DEPTH];
  logic [SLOT_W-1:0]        rd_slot    [QUEUES] = '{default: '0};
  logic [SLOT_W-1:0]        wr_slot    [QUEUES] = '{default: '0};
  logic [FILL_W-1:0]        held_count [QUEUES] = '{default: '0};
  logic [LOST_W-1:0]        drop_count [QUEUES] = '{default: '0};
  logic [MADE_W-1:0]        queues_made = '0;

  fifo_result_t pending_results [$];
  int           error_count   = 0;
  int           results_taken = 0;
  bit           sender_calm   = 1'b0;

  stim_row_t directed_rows [N_ROWS] = '{
    // Read straight after reset finds queue 0 empty.
    '{ACT_READ,  2'd0, 32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 32'd0}},
    // Word extremes through queue 3.
    '{ACT_WRITE, 2'd3, 32'sh7FFFFFFF,   5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_WRITE, 2'd3, 32'sh80000000,   5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_WRITE, 2'd3, 32'shFFFFFFFF,   5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_READ,  2'd3, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sh7FFFFFFF, 32'd0}},
    '{ACT_NONE,  2'd3, 32'shFFFFFFFF,   5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    // Init of a queue that still holds two words empties it.
    '{ACT_INIT,  2'd3, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_READ,  2'd3, 32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 32'd0}},
    '{ACT_INIT,  2'd0, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    // Fill queue 2 to DEPTH-1 words, then overflow it twice.
    '{ACT_WRITE, 2'd2, 32'sd1000,       5'd15, 1'b0, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_WRITE, 2'd2, -32'sd5,         5'd1,  1'b1, '{ST_FULL, 32'sd0, 32'd1}},
    '{ACT_WRITE, 2'd2, -32'sd6,         5'd1,  1'b1, '{ST_FULL, 32'sd0, 32'd2}},
    '{ACT_READ,  2'd2, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd1000, 32'd2}},
    '{ACT_WRITE, 2'd2, 32'sd77,         5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd2}},
    '{ACT_NONE,  2'd2, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd2}},
    '{ACT_INIT,  2'd1, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    // Fourth init clears the full queue and its drop count.
    '{ACT_INIT,  2'd2, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    // No queues left to create.
    '{ACT_INIT,  2'd0, 32'sd0,          5'd1,  1'b1, '{ST_NO_QUEUE, 32'sd0, 32'd0}},
    '{ACT_READ,  2'd2, 32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 32'd0}},
    '{ACT_WRITE, 2'd1, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_READ,  2'd1, 32'sd0,          5'd1,  1'b1, '{ST_OK, 32'sd0, 32'd0}},
    '{ACT_READ,  2'd1, 32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 32'd0}}
  };

  multi_queue_fifo_with_drop_count #(
    .QUEUES(QUEUES),
    .DEPTH (DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .queue_i     (queue_i),
    .word_in_i   (word_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .word_out_o  (word_out_o),
    .lost_total_o(lost_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one action to the predicted FIFO bank and returns its result.
  function automatic fifo_result_t apply_fifo_action(
      input logic [ACTION_W-1:0] act, input logic [QUEUE_W-1:0] q,
      input logic signed [WORD_W-1:0] word);
    fifo_result_t res;
    int unsigned  qi;
    res = '0;
    res.status = ST_OK;
    qi = q;
    if (qi >= QUEUES) begin
      res.status = ST_NO_QUEUE;
    end else begin
      case (act)
        ACT_INIT: begin
          if (queues_made >= QUEUES) begin
            res.status = ST_NO_QUEUE;
          end else begin
            rd_slot[qi]    = '0;
            wr_slot[qi]    = '0;
            held_count[qi] = '0;
            drop_count[qi] = '0;
            queues_made    = queues_made + 1'b1;
          end
        end
        ACT_WRITE: begin
          if (held_count[qi] >= DEPTH - 1) begin
            // The drop counter sticks at all ones.
            if (drop_count[qi] != '1) drop_count[qi] = drop_count[qi] + 1'b1;
            res.status = ST_FULL;
          end else begin
            bank_words[qi][wr_slot[qi]] = word;
            wr_slot[qi]    = (wr_slot[qi] == DEPTH - 1) ? '0 : wr_slot[qi] + 1'b1;
            held_count[qi] = held_count[qi] + 1'b1;
          end
        end
        ACT_READ: begin
          if (held_count[qi] == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.word       = bank_words[qi][rd_slot[qi]];
            rd_slot[qi]    = (rd_slot[qi] == DEPTH - 1) ? '0 : rd_slot[qi] + 1'b1;
            held_count[qi] = held_count[qi] - 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.lost = drop_count[qi];
    end
    return res;
  endfunction

  // Presents one beat, waits until it is taken, then records what it should
  // produce. Random gaps come first unless the sender is in its calm stretch.
  task automatic offer_beat(input logic [ACTION_W-1:0] act, input logic [QUEUE_W-1:0] q,
                            input logic signed [WORD_W-1:0] word, input logic typed,
                            input fifo_result_t typed_res);
    fifo_result_t predicted;
    if (!sender_calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    queue_i    <= q;
    word_in_i  <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_fifo_action(act, q, word);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Result side: checks each accepted beat and decides the stall for the next
  // cycle. The long hold-off is counted here so that the block fills up and
  // pushes back on the sender, which keeps offering beats meanwhile.
  always @(posedge clk_i) begin : result_check
    fifo_result_t want;
    int           hold_left;
    bit           hold_done;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: status %0d word %0d lost %0d",
                 status_o, word_out_o, lost_total_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (word_out_o !== want.word) begin
            $error("word_out: expected %0d, got %0d", want.word, word_out_o);
            error_count++;
          end
          if (lost_total_o !== want.lost) begin
            $error("lost_total: expected %0d, got %0d", want.lost, lost_total_o);
            error_count++;
          end
        end
        results_taken++;
      end
      if (results_taken == HOLD_AT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (results_taken >= 250 && results_taken < 450) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    fifo_result_t            no_res;
    logic [ACTION_W-1:0]     act;
    logic [QUEUE_W-1:0]      q;
    logic signed [WORD_W-1:0] word;
    int                      focus_q;
    int                      write_pct;
    int                      pick;
    no_res = '0;
    focus_q = 0;
    write_pct = 50;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        offer_beat(directed_rows[r].act, directed_rows[r].q,
                   directed_rows[r].word + WORD_W'(k), directed_rows[r].typed,
                   directed_rows[r].res);
      end
    end

    // Random bursts: each burst leans on one queue and either fills it past
    // the drop point, drains it to empty, or mixes the two.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % BURST_LEN == 0) begin
        focus_q = $urandom_range(QUEUES - 1);
        case ($urandom_range(3))
          0:       write_pct = 10;
          1:       write_pct = 50;
          2:       write_pct = 90;
          default: write_pct = $urandom_range(100);
        endcase
      end
      sender_calm = (n >= 200 && n < 400);
      if (n == 500) begin
        // Let every outstanding result come back before going on.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      pick = $urandom_range(99);
      if (pick < 3) act = ACT_INIT;
      else if (pick < 5) act = ACT_NONE;
      else if ($urandom_range(99) < write_pct) act = ACT_WRITE;
      else act = ACT_READ;
      q = ($urandom_range(3) != 0) ? QUEUE_W'(focus_q) : QUEUE_W'($urandom_range(3));
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       word = 32'sh7FFFFFFF;
          1:       word = 32'sh80000000;
          2:       word = 32'shFFFFFFFF;
          default: word = 32'sd0;
        endcase
      end else begin
        word = $urandom;
      end
      offer_beat(act, q, word, 1'b0, no_res);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Keep the clock running so that any stray result beat is caught.
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
